// ----- hw/rtl/mer_pkg.sv -----
// ============================================================================
// mer_pkg - shared types and microcode for the midpoint ellipse rasterizer
// Control word layout, sequencer addresses and the microprogram ROM.
// ============================================================================
package mer_pkg;

    // Operation codes carried on the input tuser bit
    localparam logic OP_START = 1'b0;
    localparam logic OP_STEP  = 1'b1;

    // Tracing region
    typedef enum logic [1:0] {
        REGION_DONE = 2'd0,
        REGION_ONE  = 2'd1,
        REGION_TWO  = 2'd2
    } t_region;

    // Multiplier operand pairs (product lands in the P register)
    typedef enum logic [3:0] {
        MUL_NONE,
        MUL_RXRX,
        MUL_RYRY,
        MUL_RX2RY,
        MUL_TXTX,
        MUL_RY2P,
        MUL_TYTY,
        MUL_RX2P,
        MUL_RX2RY2
    } t_mul_sel;

    // Loads from P into the squared-radius registers
    typedef enum logic [1:0] {
        LD_NONE,
        LD_RX2,
        LD_RY2
    } t_ld;

    // Decision accumulator operations
    typedef enum logic [2:0] {
        D_HOLD,
        D_LD4P,
        D_LDP,
        D_ADD4P,
        D_SUB4P,
        D_ADDRX2,
        D_R1,
        D_R2
    } t_d_op;

    // Walk position / slope term updates
    typedef enum logic [1:0] {
        XY_HOLD,
        XY_PY2P,
        XY_R1,
        XY_R2
    } t_xy_op;

    typedef enum logic [1:0] {
        RGOP_HOLD,
        RGOP_TWO,
        RGOP_DONE
    } t_rg_op;

    typedef enum logic [2:0] {
        EM_NONE,
        EM_PIX0,
        EM_PIX1,
        EM_PIX2,
        EM_PIX3,
        EM_DONE
    } t_emit;

    // Jump conditions
    typedef enum logic [2:0] {
        C_NEVER,
        C_ALWAYS,
        C_DONE,
        C_TWO,
        C_PX_GT_PY,
        C_Y_ZERO
    } t_cond;

    localparam int PC_W = 5;
    typedef logic [PC_W-1:0] t_pc;

    // Program entry points and jump targets
    localparam t_pc PC_IDLE      = 5'd0;
    localparam t_pc PC_START     = 5'd1;
    localparam t_pc PC_STEP      = 5'd6;
    localparam t_pc PC_R2_INIT   = 5'd11;
    localparam t_pc PC_R2        = 5'd17;
    localparam t_pc PC_EMIT      = 5'd20;
    localparam t_pc PC_R2_END    = 5'd24;
    localparam t_pc PC_EMIT_DONE = 5'd25;

    typedef struct packed {
        logic     fetch;
        t_mul_sel mul;
        t_ld      ld;
        t_d_op    dop;
        t_xy_op   xyop;
        t_rg_op   rgop;
        t_emit    emit;
        t_cond    cond;
        t_pc      target;
    } t_uword;

    localparam t_uword UW_NOP = '{
        fetch:  1'b0,
        mul:    MUL_NONE,
        ld:     LD_NONE,
        dop:    D_HOLD,
        xyop:   XY_HOLD,
        rgop:   RGOP_HOLD,
        emit:   EM_NONE,
        cond:   C_NEVER,
        target: PC_IDLE
    };

    // Microprogram ROM
    function automatic t_uword ucode(input t_pc pc);
        t_uword w;
        w = UW_NOP;
        case (pc)
            5'd0: begin                       // idle, wait for an input transfer
                w.fetch = 1'b1;
            end
            // start: rx2, ry2, d = 4ry2 - 4rx2*ry + rx2, py = 2rx2*ry
            5'd1: begin
                w.mul = MUL_RXRX;
            end
            5'd2: begin
                w.ld  = LD_RX2;
                w.mul = MUL_RYRY;
            end
            5'd3: begin
                w.ld  = LD_RY2;
                w.mul = MUL_RX2RY;
                w.dop = D_LD4P;
            end
            5'd4: begin
                w.dop  = D_SUB4P;
                w.xyop = XY_PY2P;
            end
            5'd5: begin
                w.dop    = D_ADDRX2;
                w.cond   = C_ALWAYS;
                w.target = PC_IDLE;
            end
            // step: dispatch on region
            5'd6: begin
                w.cond   = C_DONE;
                w.target = PC_EMIT_DONE;
            end
            5'd7: begin
                w.cond   = C_TWO;
                w.target = PC_R2;
            end
            5'd8: begin
                w.cond   = C_PX_GT_PY;
                w.target = PC_R2_INIT;
            end
            // region 1 iteration
            5'd9: begin
                w.xyop = XY_R1;
            end
            5'd10: begin
                w.dop    = D_R1;
                w.cond   = C_ALWAYS;
                w.target = PC_EMIT;
            end
            // region 2 seed: ry2*tx^2 + 4rx2*ty^2 - 4rx2*ry2
            5'd11: begin
                w.mul = MUL_TXTX;
            end
            5'd12: begin
                w.mul = MUL_RY2P;
            end
            5'd13: begin
                w.dop = D_LDP;
                w.mul = MUL_TYTY;
            end
            5'd14: begin
                w.mul = MUL_RX2P;
            end
            5'd15: begin
                w.dop = D_ADD4P;
                w.mul = MUL_RX2RY2;
            end
            5'd16: begin
                w.dop  = D_SUB4P;
                w.rgop = RGOP_TWO;
            end
            // region 2 iteration
            5'd17: begin
                w.cond   = C_Y_ZERO;
                w.target = PC_R2_END;
            end
            5'd18: begin
                w.xyop = XY_R2;
            end
            5'd19: begin
                w.dop = D_R2;
            end
            // four mirrored pixels
            5'd20: begin
                w.emit = EM_PIX0;
            end
            5'd21: begin
                w.emit = EM_PIX1;
            end
            5'd22: begin
                w.emit = EM_PIX2;
            end
            5'd23: begin
                w.emit   = EM_PIX3;
                w.cond   = C_ALWAYS;
                w.target = PC_IDLE;
            end
            5'd24: begin
                w.rgop = RGOP_DONE;
            end
            5'd25: begin
                w.emit   = EM_DONE;
                w.cond   = C_ALWAYS;
                w.target = PC_IDLE;
            end
            default: begin
                w.cond   = C_ALWAYS;
                w.target = PC_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage

// ----- hw/rtl/midpoint_ellipse_rasterizer.sv -----
// ============================================================================
// midpoint_ellipse_rasterizer - microcoded midpoint ellipse tracer
// Start transfers load an ellipse; step transfers run one midpoint iteration
// and return the four mirrored pixels, or a done marker once traced.
// ============================================================================
//
//  channel | dir | tdata (low bit first)                      | tuser / tlast
//  --------+-----+--------------------------------------------+-----------------------
//  s_axis  | in  | center_x, center_y, radius_x, radius_y,    | tuser: operation
//          |     | pen_color, zero pad                        |  (0 start, 1 step)
//  m_axis  | out | pixel_x, pixel_y, pixel_color, zero pad    | tuser: pixel_valid,
//          |     |                                            |  arc_done; tlast: last
//
//  A start runs 5 microcode words on the one multiplier after its transfer; a step runs one
//  midpoint iteration in either region, after five chained multiplies when it crosses into region 2,
//  and returns a done marker once the arc is finished. One pixel leaves per cycle while the output is taken.
//  Reset: i_rst_n low at a clock edge returns the sequencer to idle, the region to done,
//  empties the output register and holds s_axis_tready low.
//  Stalls: a pixel word holds while the output register is full and not taken; the next
//  input transfer is taken while the last result still waits.
//
module midpoint_ellipse_rasterizer #(
    parameter int RADIUS_BITS = 9,
    parameter int COORD_BITS  = 12,
    localparam int CENTER_BITS = COORD_BITS - 2,
    localparam int IN_FW       = 2 * CENTER_BITS + 2 * RADIUS_BITS + 4,
    localparam int IN_DW       = ((IN_FW + 7) / 8) * 8,
    localparam int OUT_FW      = 2 * COORD_BITS + 4,
    localparam int OUT_DW      = ((OUT_FW + 7) / 8) * 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // center_x, center_y, radius_x, radius_y, pen_color, pad
    input  logic [IN_DW-1:0]  s_axis_tdata,
    input  logic              s_axis_tuser,     // operation
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    // pixel_x, pixel_y, pixel_color, pad
    output logic [OUT_DW-1:0] m_axis_tdata,
    output logic [1:0]        m_axis_tuser,     // pixel_valid, arc_done
    output logic              m_axis_tlast,     // last_of_step
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready
);

    import mer_pkg::*;

    localparam int WW = RADIUS_BITS + 2;         // walk x / y
    localparam int R2W = 2 * RADIUS_BITS;        // squared radius
    localparam int MW = 2 * RADIUS_BITS + 4;     // multiplier operand
    localparam int DW = 4 * RADIUS_BITS + 6;     // decision and slope terms
    localparam int SW = COORD_BITS + WW;         // pixel add width

    // input field offsets
    localparam int CY_LO = CENTER_BITS;
    localparam int RX_LO = 2 * CENTER_BITS;
    localparam int RY_LO = RX_LO + RADIUS_BITS;
    localparam int PC_LO = RY_LO + RADIUS_BITS;

    // ---------------- registers ----------------
    t_pc     r_pc, n_pc;
    t_region r_region;

    logic [CENTER_BITS-1:0] r_cx, r_cy;
    logic [RADIUS_BITS-1:0] r_rx, r_ry;
    logic [3:0]             r_color;
    logic [R2W-1:0]         r_rx2, r_ry2;
    logic [WW-1:0]          r_x, r_y;
    logic signed [DW-1:0]   r_px, r_py, r_d;
    logic [DW-1:0]          r_p;
    logic                   r_flag;

    logic                   r_o_valid;
    logic [COORD_BITS-1:0]  r_o_x, r_o_y;
    logic [3:0]             r_o_color;
    logic                   r_o_pv, r_o_done, r_o_last;

    // ---------------- control word ----------------
    t_uword uw;
    logic   s_fire;
    logic   emit_stall;
    logic   emit_load;
    logic   cond_true;

    assign uw         = ucode(r_pc);
    assign s_axis_tready = uw.fetch && i_rst_n;
    assign s_fire     = s_axis_tvalid && s_axis_tready;
    assign emit_stall = (uw.emit != EM_NONE) && r_o_valid && !m_axis_tready;
    assign emit_load  = (uw.emit != EM_NONE) && !emit_stall;

    always_comb begin
        case (uw.cond)
            C_NEVER:    cond_true = 1'b0;
            C_ALWAYS:   cond_true = 1'b1;
            C_DONE:     cond_true = (r_region == REGION_DONE);
            C_TWO:      cond_true = (r_region == REGION_TWO);
            C_PX_GT_PY: cond_true = (r_px > r_py);
            C_Y_ZERO:   cond_true = (r_y == '0);
            default:    cond_true = 1'b0;
        endcase
    end

    // sequencer next address
    always_comb begin
        n_pc = r_pc + t_pc'(1);
        if (uw.fetch) begin
            if (s_fire) begin
                n_pc = (s_axis_tuser == OP_START) ? PC_START : PC_STEP;
            end else begin
                n_pc = r_pc;
            end
        end else if (emit_stall) begin
            n_pc = r_pc;
        end else if (cond_true) begin
            n_pc = uw.target;
        end
    end

    // ---------------- shared multiplier ----------------
    logic [MW-1:0]   mul_a, mul_b;
    logic [2*MW-1:0] mul_prod;
    logic [WW:0]     tx;
    logic [WW-1:0]   ty;

    assign tx = {r_x, 1'b1};                                  // 2x + 1
    assign ty = (r_y == '0) ? WW'(1) : r_y - WW'(1);          // |y - 1|

    always_comb begin
        case (uw.mul)
            MUL_RXRX: begin
                mul_a = MW'(r_rx);
                mul_b = MW'(r_rx);
            end
            MUL_RYRY: begin
                mul_a = MW'(r_ry);
                mul_b = MW'(r_ry);
            end
            MUL_RX2RY: begin
                mul_a = MW'(r_rx2);
                mul_b = MW'(r_ry);
            end
            MUL_TXTX: begin
                mul_a = MW'(tx);
                mul_b = MW'(tx);
            end
            MUL_RY2P: begin
                mul_a = MW'(r_ry2);
                mul_b = r_p[MW-1:0];
            end
            MUL_TYTY: begin
                mul_a = MW'(ty);
                mul_b = MW'(ty);
            end
            MUL_RX2P: begin
                mul_a = MW'(r_rx2);
                mul_b = r_p[MW-1:0];
            end
            MUL_RX2RY2: begin
                mul_a = MW'(r_rx2);
                mul_b = MW'(r_ry2);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_prod = mul_a * mul_b;

    // ---------------- decision / walk datapath ----------------
    logic signed [DW-1:0] p_s, rx2_s, ry2_s;

    assign p_s   = $signed(r_p);
    assign rx2_s = $signed({{(DW - R2W){1'b0}}, r_rx2});
    assign ry2_s = $signed({{(DW - R2W){1'b0}}, r_ry2});

    // start transfers seed the walk; the microcode fills in the rest
    always_ff @(posedge i_clk) begin
        if (s_fire && (s_axis_tuser == OP_START)) begin
            r_cx    <= s_axis_tdata[CY_LO-1:0];
            r_cy    <= s_axis_tdata[RX_LO-1:CY_LO];
            r_rx    <= s_axis_tdata[RY_LO-1:RX_LO];
            r_ry    <= s_axis_tdata[PC_LO-1:RY_LO];
            r_color <= s_axis_tdata[PC_LO+3:PC_LO];
            r_x     <= '0;
            r_y     <= WW'(s_axis_tdata[PC_LO-1:RY_LO]);
            r_px    <= '0;
        end else begin
            case (uw.xyop)
                XY_PY2P: begin
                    r_py <= p_s <<< 1;
                end
                XY_R1: begin
                    r_x    <= r_x + WW'(1);
                    r_px   <= r_px + (ry2_s <<< 1);
                    r_flag <= (r_d < 0);
                    if (r_d >= 0) begin
                        r_y  <= r_y - WW'(1);
                        r_py <= r_py - (rx2_s <<< 1);
                    end
                end
                XY_R2: begin
                    r_y    <= r_y - WW'(1);
                    r_py   <= r_py - (rx2_s <<< 1);
                    r_flag <= (r_d <= 0);
                    if (r_d <= 0) begin
                        r_x  <= r_x + WW'(1);
                        r_px <= r_px + (ry2_s <<< 1);
                    end
                end
                default: begin
                end
            endcase
        end

        if (uw.mul != MUL_NONE) begin
            r_p <= mul_prod[DW-1:0];
        end

        case (uw.ld)
            LD_RX2:  r_rx2 <= r_p[R2W-1:0];
            LD_RY2:  r_ry2 <= r_p[R2W-1:0];
            default: begin
            end
        endcase

        case (uw.dop)
            D_LD4P:   r_d <= p_s <<< 2;
            D_LDP:    r_d <= p_s;
            D_ADD4P:  r_d <= r_d + (p_s <<< 2);
            D_SUB4P:  r_d <= r_d - (p_s <<< 2);
            D_ADDRX2: r_d <= r_d + rx2_s;
            D_R1: begin
                // flag set: x step only; clear: diagonal step
                if (r_flag) begin
                    r_d <= r_d + ((r_px + ry2_s) <<< 2);
                end else begin
                    r_d <= r_d + ((r_px - r_py + ry2_s) <<< 2);
                end
            end
            D_R2: begin
                if (r_flag) begin
                    r_d <= r_d + ((r_px - r_py + rx2_s) <<< 2);
                end else begin
                    r_d <= r_d + ((rx2_s - r_py) <<< 2);
                end
            end
            default: begin
            end
        endcase
    end

    // ---------------- pixel generation ----------------
    logic [SW-1:0]         cx_w, cy_w, x_w, y_w;
    logic [SW-1:0]         xp, xm, yp, ym;
    logic [COORD_BITS-1:0] n_o_x, n_o_y;
    logic [3:0]            n_o_color;
    logic                  n_o_pv, n_o_done, n_o_last;

    assign cx_w = SW'(r_cx);
    assign cy_w = SW'(r_cy);
    assign x_w  = SW'(r_x);
    assign y_w  = SW'(r_y);
    assign xp   = cx_w + x_w;
    assign xm   = cx_w - x_w;
    assign yp   = cy_w + y_w;
    assign ym   = cy_w - y_w;

    always_comb begin
        n_o_x     = '0;
        n_o_y     = '0;
        n_o_color = r_color;
        n_o_pv    = 1'b1;
        n_o_done  = 1'b0;
        n_o_last  = 1'b0;
        case (uw.emit)
            EM_PIX0: begin
                n_o_x = xp[COORD_BITS-1:0];
                n_o_y = yp[COORD_BITS-1:0];
            end
            EM_PIX1: begin
                n_o_x = xp[COORD_BITS-1:0];
                n_o_y = ym[COORD_BITS-1:0];
            end
            EM_PIX2: begin
                n_o_x = xm[COORD_BITS-1:0];
                n_o_y = yp[COORD_BITS-1:0];
            end
            EM_PIX3: begin
                n_o_x    = xm[COORD_BITS-1:0];
                n_o_y    = ym[COORD_BITS-1:0];
                n_o_last = 1'b1;
            end
            EM_DONE: begin
                n_o_color = '0;
                n_o_pv    = 1'b0;
                n_o_done  = 1'b1;
                n_o_last  = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (emit_load) begin
            r_o_x     <= n_o_x;
            r_o_y     <= n_o_y;
            r_o_color <= n_o_color;
            r_o_pv    <= n_o_pv;
            r_o_done  <= n_o_done;
            r_o_last  <= n_o_last;
        end
    end

    // ---------------- control registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc      <= PC_IDLE;
            r_region  <= REGION_DONE;
            r_o_valid <= 1'b0;
        end else begin
            r_pc <= n_pc;

            if (s_fire && (s_axis_tuser == OP_START)) begin
                // a zero semi-axis leaves nothing to trace
                if ((s_axis_tdata[RY_LO-1:RX_LO] == '0) ||
                    (s_axis_tdata[PC_LO-1:RY_LO] == '0)) begin
                    r_region <= REGION_DONE;
                end else begin
                    r_region <= REGION_ONE;
                end
            end else begin
                case (uw.rgop)
                    RGOP_TWO:  r_region <= REGION_TWO;
                    RGOP_DONE: r_region <= REGION_DONE;
                    default: begin
                    end
                endcase
            end

            if (emit_load) begin
                r_o_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // ---------------- output channel ----------------
    assign m_axis_tvalid = r_o_valid;
    assign m_axis_tdata  = OUT_DW'({r_o_color, r_o_y, r_o_x});
    assign m_axis_tuser  = {r_o_done, r_o_pv};
    assign m_axis_tlast  = r_o_last;

endmodule
